[sv/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared widths, case codes and a magnitude helper for the bounding sphere merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // Field widths.
  localparam int CW = 32;   // center coordinate
  localparam int RW = 31;   // radius and loose bound

  // Internal widths.
  localparam int DW     = 33;  // signed center difference and its magnitude
  localparam int PW     = 66;  // serial multiplier product
  localparam int SUM_W  = 68;  // sum of three squares
  localparam int RAD_W  = 70;  // radicand padded to whole bit pairs
  localparam int ROOT_W = 35;  // square root
  localparam int KW     = 36;  // dividend of the move fraction
  localparam int TW     = 31;  // move fraction, Q.30 in [0,1]
  localparam int T_FRAC = 30;

  // Merge case codes.
  localparam logic [2:0] MC_EMPTY   = 3'd0;
  localparam logic [2:0] MC_COPY    = 3'd1;
  localparam logic [2:0] MC_CONC    = 3'd2;
  localparam logic [2:0] MC_INSIDE  = 3'd3;
  localparam logic [2:0] MC_STORED  = 3'd4;
  localparam logic [2:0] MC_GROWN   = 3'd5;

  // Magnitude of a signed difference.
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] r;
    r = v[DW-1] ? DW'(-v) : DW'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/bsm_mul.sv]
// ----------------------------------------------------------------------------
// bsm_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_mul (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [bsm_pkg::DW-1:0]  a,
  input  wire logic [bsm_pkg::DW-1:0]  b,
  output logic                         done,
  output logic [bsm_pkg::PW-1:0]       prod
);

  localparam int CNTW = $clog2(bsm_pkg::DW + 1);

  logic [bsm_pkg::DW-1:0] a_r;
  logic [CNTW-1:0]        cnt;
  logic                   busy;
  logic [bsm_pkg::DW:0]   hi_sum;

  // Upper half plus the multiplicand when the current multiplier bit is set.
  assign hi_sum = {1'b0, prod[bsm_pkg::PW-1:bsm_pkg::DW]} +
                  {1'b0, (prod[0] ? a_r : '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_r  <= a;
        prod <= {{bsm_pkg::DW{1'b0}}, b};
      end else if (busy) begin
        prod <= {hi_sum, prod[bsm_pkg::DW-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == CNTW'(bsm_pkg::DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/bsm_sqrt.sv]
// ----------------------------------------------------------------------------
// bsm_sqrt
// Floor square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bsm_pkg::SUM_W-1:0]   radicand,
  output logic                             done,
  output logic [bsm_pkg::ROOT_W-1:0]       root
);

  localparam int REMW = bsm_pkg::ROOT_W + 2;
  localparam int CNTW = $clog2(bsm_pkg::ROOT_W + 1);

  logic [bsm_pkg::RAD_W-1:0] rad;
  logic [REMW-1:0]           rem;
  logic [CNTW-1:0]           cnt;
  logic                      busy;
  logic [REMW+1:0]           cur;
  logic [REMW+1:0]           trial;

  // Bring down the next bit pair and try the next root bit.
  assign cur   = {rem, rad[bsm_pkg::RAD_W-1:bsm_pkg::RAD_W-2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= bsm_pkg::RAD_W'(radicand);
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[bsm_pkg::RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
          rem  <= REMW'(cur - trial);
          root <= {root[bsm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= cur[REMW-1:0];
          root <= {root[bsm_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(bsm_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/bsm_div.sv]
// ----------------------------------------------------------------------------
// bsm_div
// Restoring divider for the move fraction floor(k * 2^29 / d), k <= 2d.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bsm_pkg::KW-1:0]      k,
  input  wire logic [bsm_pkg::ROOT_W-1:0]  d,
  output logic                             done,
  output logic [bsm_pkg::TW-1:0]           q
);

  localparam int CNTW = $clog2(bsm_pkg::TW + 1);

  logic [bsm_pkg::ROOT_W-1:0] d_r;
  logic [bsm_pkg::ROOT_W-1:0] rem;
  logic [bsm_pkg::TW-1:0]     num;
  logic [CNTW-1:0]            cnt;
  logic                       busy;
  logic [bsm_pkg::ROOT_W:0]   rem2;

  assign rem2 = {rem, num[bsm_pkg::TW-1]};

  // The dividend k * 2^29 starts with k / 4 as the partial remainder, which
  // stays below d, so the quotient fits the fraction width.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        d_r  <= d;
        rem  <= bsm_pkg::ROOT_W'(k >> 2);
        num  <= {k[1:0], {(bsm_pkg::TW-2){1'b0}}};
        q    <= '0;
      end else if (busy) begin
        num <= {num[bsm_pkg::TW-2:0], 1'b0};
        if (rem2 >= {1'b0, d_r}) begin
          rem <= bsm_pkg::ROOT_W'(rem2 - {1'b0, d_r});
          q   <= {q[bsm_pkg::TW-2:0], 1'b1};
        end else begin
          rem <= rem2[bsm_pkg::ROOT_W-1:0];
          q   <= {q[bsm_pkg::TW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(bsm_pkg::TW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/bounding_sphere_merge.sv]
// ----------------------------------------------------------------------------
// bounding_sphere_merge
// Accumulates a bounding sphere over a stream of input spheres.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one sphere per transaction:
//   start_new, a signed center and an unsigned radius and loose bound. Each
//   input produces exactly one result transaction on the output channel
//   (out_valid / out_stall) with the stored sphere after the merge and a
//   merge case code.
//   Flow: an empty input or a copy goes straight from acceptance to the output
//   state; every other case first forms the three squares on the bit-serial
//   multiplier and the distance on the bit-pair square root, after which a
//   same-center, inside or stored case is done. A grown sphere then runs the
//   restoring divider and the three center moves on the multiplier.
//   One input is processed at a time; in_stall is high while an input is at
//   work. A finished result waits in the output register, and the next input
//   may be accepted meanwhile; a stalled receiver only delays the following
//   result. Reset clears the stored sphere, the loose bound and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_sphere_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          start_new,
  input  wire logic signed [bsm_pkg::CW-1:0] in_cx,
  input  wire logic signed [bsm_pkg::CW-1:0] in_cy,
  input  wire logic signed [bsm_pkg::CW-1:0] in_cz,
  input  wire logic [bsm_pkg::RW-1:0]        in_radius,
  input  wire logic [bsm_pkg::RW-1:0]        in_max_radius,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [bsm_pkg::CW-1:0]      out_cx,
  output logic signed [bsm_pkg::CW-1:0]      out_cy,
  output logic signed [bsm_pkg::CW-1:0]      out_cz,
  output logic [bsm_pkg::RW-1:0]             out_radius,
  output logic [bsm_pkg::RW-1:0]             out_max_radius,
  output logic [2:0]                         merge_case
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MV   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int CW = bsm_pkg::CW;
  localparam int RW = bsm_pkg::RW;
  localparam int DW = bsm_pkg::DW;
  localparam int NW = 39;  // center move arithmetic

  logic [2:0]                 state;
  logic                       run;
  logic [1:0]                 idx;
  logic signed [CW-1:0]       acc_c [3];
  logic [RW-1:0]              acc_r;
  logic [RW-1:0]              acc_mb;
  logic signed [CW-1:0]       in_c  [3];
  logic [RW-1:0]              in_r;
  logic signed [DW-1:0]       dlt   [3];
  logic [bsm_pkg::SUM_W-1:0]  sumsq;
  logic [bsm_pkg::ROOT_W-1:0] dist_r;
  logic [bsm_pkg::KW-1:0]     kval;
  logic [bsm_pkg::TW-1:0]     tq;
  logic [RW-1:0]              nr;
  logic [2:0]                 mc;

  logic                       mul_start, mul_done;
  logic [DW-1:0]              mul_a, mul_b;
  logic [bsm_pkg::PW-1:0]     mul_prod;
  logic                       sqrt_start, sqrt_done;
  logic [bsm_pkg::ROOT_W-1:0] sqrt_root;
  logic                       div_start, div_done;
  logic [bsm_pkg::TW-1:0]     div_q;

  logic [RW-1:0]              eff_r, eff_mb, mb_max;
  logic [36:0]                d_plus_rin, d_plus_racc, nr_sum;
  logic [bsm_pkg::PW:0]       rnd;
  logic [36:0]                mv_m;
  logic signed [NW-1:0]       mv_new;
  logic signed [CW-1:0]       mv_sat;

  assign in_stall = (state != S_IDLE);

  // Effective stored values at acceptance, after an optional clear.
  assign eff_r  = start_new ? '0 : acc_r;
  assign eff_mb = start_new ? '0 : acc_mb;
  assign mb_max = (eff_mb < in_max_radius) ? in_max_radius : eff_mb;

  // Containment tests and new radius from the floored distance.
  assign d_plus_rin  = 37'(sqrt_root) + 37'(in_r);
  assign d_plus_racc = 37'(sqrt_root) + 37'(acc_r);
  assign nr_sum      = (d_plus_racc + 37'(in_r)) >> 1;

  // Center move: round dx * t to nearest, then add or subtract and saturate.
  assign rnd    = {1'b0, mul_prod} + (67'(1) << (bsm_pkg::T_FRAC - 1));
  assign mv_m   = rnd[bsm_pkg::T_FRAC+36:bsm_pkg::T_FRAC];
  assign mv_new = dlt[idx][DW-1]
                ? $signed(NW'(acc_c[idx])) - $signed({2'b00, mv_m})
                : $signed(NW'(acc_c[idx])) + $signed({2'b00, mv_m});

  always_comb begin
    if (mv_new > $signed(NW'(32'sh7FFFFFFF))) begin
      mv_sat = 32'sh7FFFFFFF;
    end else if (mv_new < $signed(NW'(32'sh80000000))) begin
      mv_sat = 32'sh80000000;
    end else begin
      mv_sat = mv_new[CW-1:0];
    end
  end

  // Multiplier operands: squares of the differences, then difference times t.
  assign mul_a      = bsm_pkg::mag(dlt[idx]);
  assign mul_b      = (state == S_MV) ? DW'(tq) : bsm_pkg::mag(dlt[idx]);
  assign mul_start  = ((state == S_SQ) || (state == S_MV)) && !run;
  assign sqrt_start = (state == S_SQRT) && !run;
  assign div_start  = (state == S_DIV) && !run;

  bsm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  bsm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sumsq),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  bsm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .k     (kval),
    .d     (dist_r),
    .done  (div_done),
    .q     (div_q)
  );

  // Merge sequencer and stored sphere.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      run       <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
      acc_c[0]  <= '0;
      acc_c[1]  <= '0;
      acc_c[2]  <= '0;
      acc_r     <= '0;
      acc_mb    <= '0;
    end else begin
      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (mul_start || sqrt_start || div_start) begin
        run <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_c[0] <= in_cx;
            in_c[1] <= in_cy;
            in_c[2] <= in_cz;
            in_r    <= in_radius;
            if (in_radius == '0) begin
              if (start_new) begin
                acc_c[0] <= '0;
                acc_c[1] <= '0;
                acc_c[2] <= '0;
              end
              acc_r  <= eff_r;
              acc_mb <= mb_max;
              mc     <= bsm_pkg::MC_EMPTY;
              state  <= S_OUT;
            end else if (eff_r == '0) begin
              acc_c[0] <= in_cx;
              acc_c[1] <= in_cy;
              acc_c[2] <= in_cz;
              acc_r    <= in_radius;
              acc_mb   <= in_max_radius;
              mc       <= bsm_pkg::MC_COPY;
              state    <= S_OUT;
            end else begin
              acc_mb <= mb_max;
              dlt[0] <= $signed({in_cx[CW-1], in_cx}) - $signed({acc_c[0][CW-1], acc_c[0]});
              dlt[1] <= $signed({in_cy[CW-1], in_cy}) - $signed({acc_c[1][CW-1], acc_c[1]});
              dlt[2] <= $signed({in_cz[CW-1], in_cz}) - $signed({acc_c[2][CW-1], acc_c[2]});
              sumsq  <= '0;
              idx    <= '0;
              state  <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (mul_done) begin
            run   <= 1'b0;
            sumsq <= sumsq + bsm_pkg::SUM_W'(mul_prod);
            if (idx == 2'd2) begin
              idx   <= '0;
              state <= S_SQRT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            run    <= 1'b0;
            dist_r <= sqrt_root;
            kval   <= bsm_pkg::KW'(d_plus_rin - 37'(acc_r));
            nr     <= (nr_sum > 37'h7FFFFFFF) ? {RW{1'b1}} : nr_sum[RW-1:0];
            priority if (sqrt_root == '0) begin
              if (in_r > acc_r) begin
                acc_r <= in_r;
              end
              mc    <= bsm_pkg::MC_CONC;
              state <= S_OUT;
            end else if (37'(acc_r) > d_plus_rin) begin
              mc    <= bsm_pkg::MC_INSIDE;
              state <= S_OUT;
            end else if (d_plus_racc < 37'(in_r)) begin
              acc_c[0] <= in_c[0];
              acc_c[1] <= in_c[1];
              acc_c[2] <= in_c[2];
              acc_r    <= in_r;
              mc       <= bsm_pkg::MC_STORED;
              state    <= S_OUT;
            end else begin
              mc    <= bsm_pkg::MC_GROWN;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            run   <= 1'b0;
            tq    <= div_q;
            idx   <= '0;
            state <= S_MV;
          end
        end
        S_MV: begin
          if (mul_done) begin
            run        <= 1'b0;
            acc_c[idx] <= mv_sat;
            if (idx == 2'd2) begin
              idx   <= '0;
              acc_r <= nr;
              state <= S_OUT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register, loaded when the result leaves the sequencer.
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      out_cx         <= acc_c[0];
      out_cy         <= acc_c[1];
      out_cz         <= acc_c[2];
      out_radius     <= acc_r;
      out_max_radius <= acc_mb;
      merge_case     <= mc;
    end
  end

endmodule

`default_nettype wire
